// ===== hw/rtl/nbg_pkg.sv =====
package nbg_pkg;

    // Fixed field widths of the streams
    localparam int IDX_FIELD_W = 6;
    localparam int POS_FIELD_W = 32;
    localparam int DATA_W      = 104;
    localparam int DT_W        = 16;
    localparam int COUNT_W     = 7;

    // Force accumulator and pair term widths (terms are limited to 2^52)
    localparam int TERM_W = 54;
    localparam int ACC_W  = 60;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_DT    = 1'b1;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic clr_acc;
        logic rd;
        logic pair_start;
        logic mul_force;
        logic vel_wr;
        logic mul_vel;
        logic pos_wr;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic pair_done;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/nbg_pair.sv =====
module nbg_pair #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [3*COORD_WIDTH-1:0]                pos_i,
    input  logic [3*COORD_WIDTH-1:0]                pos_j,
    output logic                                    done,
    output logic signed [nbg_pkg::TERM_W-1:0]       term [3]
);

    localparam int CW  = COORD_WIDTH;
    localparam int A_W = CW + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NORM,
        PH_SQ,
        PH_SQRT,
        PH_DEN,
        PH_DIV,
        PH_TERM
    } phase_t;

    phase_t                         phase_reg;
    logic                           done_reg;
    logic                           neg_reg  [3];
    logic [A_W-1:0]                 a_reg    [3];
    logic signed [6:0]              k_reg;
    logic [33:0]                    s_reg;
    logic [33:0]                    rem_reg;
    logic [34:0]                    root_reg;
    logic [33:0]                    bit_reg;
    logic [50:0]                    den_reg;
    logic [62:0]                    nrem_reg [3];
    logic [67:0]                    dsh_reg;
    logic [17:0]                    q_reg    [3];
    logic [4:0]                     cnt_reg;
    logic signed [nbg_pkg::TERM_W-1:0] term_reg [3];

    logic signed [CW:0]             d_w      [3];
    logic [A_W-1:0]                 mag_w    [3];
    logic [A_W-1:0]                 m_max;
    logic [33:0]                    sq_sum;
    logic [34:0]                    trial;
    logic signed [7:0]              e_val;
    logic [7:0]                     ne_val;
    logic [63:0]                    t_w      [3];
    logic [63:0]                    sh_w     [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            d_w[c] = $signed({pos_j[c*CW + CW - 1], pos_j[c*CW +: CW]})
                   - $signed({pos_i[c*CW + CW - 1], pos_i[c*CW +: CW]});
            mag_w[c] = d_w[c][CW] ? A_W'(-d_w[c]) : A_W'(d_w[c]);
        end
        m_max = a_reg[0];
        if (a_reg[1] > m_max)
        begin
            m_max = a_reg[1];
        end
        if (a_reg[2] > m_max)
        begin
            m_max = a_reg[2];
        end
        sq_sum = 34'(a_reg[0][15:0] * a_reg[0][15:0])
               + 34'(a_reg[1][15:0] * a_reg[1][15:0])
               + 34'(a_reg[2][15:0] * a_reg[2][15:0]);
        trial  = root_reg + 35'(bit_reg);
        e_val  = 8'sd1 - ($signed({k_reg[6], k_reg}) <<< 1);
        ne_val = 8'(-e_val);
        for (int c = 0; c < 3; c++)
        begin
            sh_w[c] = 64'(q_reg[c]) << e_val[5:0];
            if (!e_val[7])
            begin
                t_w[c] = (sh_w[c] > (64'd1 << 52)) ? (64'd1 << 52) : sh_w[c];
            end
            else if (ne_val >= 8'd64)
            begin
                t_w[c] = '0;
            end
            else
            begin
                t_w[c] = 64'(q_reg[c]) >> ne_val[5:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_NORM;
                    end
                end
                PH_NORM:
                begin
                    if (m_max == '0)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else if (m_max[A_W-1:16] == '0 && m_max[15])
                    begin
                        phase_reg <= PH_SQ;
                    end
                end
                PH_SQ:   phase_reg <= PH_SQRT;
                PH_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        phase_reg <= PH_DEN;
                    end
                end
                PH_DEN:  phase_reg <= PH_DIV;
                PH_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= PH_TERM;
                    end
                end
                PH_TERM:
                begin
                    phase_reg <= PH_IDLE;
                    done_reg  <= 1'b1;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    // Datapath of the pair term: normalise, square, root, divide, scale
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        a_reg[c]    <= mag_w[c];
                        neg_reg[c]  <= d_w[c][CW];
                        term_reg[c] <= '0;
                    end
                    k_reg <= '0;
                end
            end
            PH_NORM:
            begin
                if (m_max[A_W-1:16] != '0)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        a_reg[c] <= a_reg[c] >> 1;
                    end
                    k_reg <= k_reg + 7'sd1;
                end
                else if (!m_max[15] && m_max != '0)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        a_reg[c] <= a_reg[c] << 1;
                    end
                    k_reg <= k_reg - 7'sd1;
                end
            end
            PH_SQ:
            begin
                s_reg    <= sq_sum;
                rem_reg  <= sq_sum;
                root_reg <= '0;
                bit_reg  <= 34'd1 << 32;
            end
            PH_SQRT:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_reg  <= rem_reg - trial[33:0];
                    root_reg <= (root_reg >> 1) + 35'(bit_reg);
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            PH_DEN:
            begin
                den_reg <= 51'(s_reg * root_reg[16:0]);
                cnt_reg <= 5'd17;
                for (int c = 0; c < 3; c++)
                begin
                    nrem_reg[c] <= {a_reg[c][15:0], 47'd0};
                    q_reg[c]    <= '0;
                end
            end
            PH_DIV:
            begin
                if (cnt_reg == 5'd17)
                begin
                    dsh_reg <= {den_reg, 17'd0} >> 1;
                end
                else
                begin
                    dsh_reg <= dsh_reg >> 1;
                end
                for (int c = 0; c < 3; c++)
                begin
                    if (68'(nrem_reg[c]) >= ((cnt_reg == 5'd17) ? {den_reg, 17'd0} : dsh_reg))
                    begin
                        nrem_reg[c] <= nrem_reg[c]
                            - ((cnt_reg == 5'd17) ? 63'({den_reg, 17'd0}) : dsh_reg[62:0]);
                        q_reg[c]    <= {q_reg[c][16:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[c] <= {q_reg[c][16:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            PH_TERM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    term_reg[c] <= neg_reg[c] ? -$signed(t_w[c][nbg_pkg::TERM_W-1:0])
                                              : $signed(t_w[c][nbg_pkg::TERM_W-1:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            term[c] = term_reg[c];
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> phase_reg == PH_IDLE)
        else $error("pair unit started while busy");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DEN |-> root_reg[34:17] == '0)
        else $error("square root exceeds 17 bits");

endmodule

// ===== hw/rtl/nbg_dp.sv =====
module nbg_dp #(
    parameter int MAX_PARTICLES = 64,
    parameter int COORD_WIDTH   = 32,
    parameter int IDX_W         = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nbg_pkg::cmd_t                     cmd,
    output nbg_pkg::stat_t                    stat,
    input  logic [IDX_W-1:0]                  i_idx,
    input  logic [IDX_W-1:0]                  j_idx,
    input  logic [nbg_pkg::IDX_FIELD_W-1:0]   ld_index,
    input  logic signed [nbg_pkg::POS_FIELD_W-1:0] ld_x,
    input  logic signed [nbg_pkg::POS_FIELD_W-1:0] ld_y,
    input  logic signed [nbg_pkg::POS_FIELD_W-1:0] ld_z,
    input  logic [nbg_pkg::DT_W-1:0]          time_step,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [nbg_pkg::DATA_W-1:0]        m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int CW = COORD_WIDTH;
    localparam logic signed [63:0] C_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] C_MIN = -C_MAX - 64'sd1;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > C_MAX)
        begin
            r = C_MAX;
        end
        else if (v < C_MIN)
        begin
            r = C_MIN;
        end
        return r[CW-1:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > 64'sd2147483647)
        begin
            w = 64'sd2147483647;
        end
        else if (w < -64'sd2147483648)
        begin
            w = -64'sd2147483648;
        end
        return w[31:0];
    endfunction

    logic [3*CW-1:0]                 pos_mem [MAX_PARTICLES];
    logic [3*CW-1:0]                 vel_mem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0]        vel_vld_reg;
    logic [3*CW-1:0]                 pos_a_reg;
    logic [3*CW-1:0]                 pos_b_reg;
    logic [3*CW-1:0]                 vel_rd_reg;
    logic                            vel_rd_vld_reg;
    logic signed [nbg_pkg::ACC_W-1:0] acc_reg [3];
    logic signed [CW:0]              prod_reg [3];
    logic                            m_valid_reg;
    logic [nbg_pkg::DATA_W-1:0]      m_data_reg;
    logic                            m_last_reg;

    logic                            ld_ok;
    logic [IDX_W-1:0]                ld_addr;
    logic signed [CW-1:0]            pa    [3];
    logic signed [CW-1:0]            vr    [3];
    logic signed [CW-1:0]            src   [3];
    logic [CW-1:0]                   mag   [3];
    logic [CW+15:0]                  prod_w [3];
    logic signed [CW:0]              prod_next [3];
    logic [3*CW-1:0]                 new_vel;
    logic [3*CW-1:0]                 new_pos;
    logic [3*CW-1:0]                 ld_pos;
    logic                            pair_done;
    logic signed [nbg_pkg::TERM_W-1:0] term [3];

    assign ld_ok   = {1'b0, ld_index} < (nbg_pkg::IDX_FIELD_W + 1)'(MAX_PARTICLES);
    assign ld_addr = ld_index[IDX_W-1:0];
    assign ld_pos  = {sat_cw(64'(ld_z)), sat_cw(64'(ld_y)), sat_cw(64'(ld_x))};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pa[c]  = pos_a_reg[c*CW +: CW];
            vr[c]  = vel_rd_vld_reg ? vel_rd_reg[c*CW +: CW] : '0;
            src[c] = cmd.mul_force ? sat_cw(64'(acc_reg[c])) : vr[c];
            // Scaling by the time step works on the magnitude, truncating toward zero
            mag[c] = src[c][CW-1] ? CW'(-src[c]) : CW'(src[c]);
            prod_w[c] = (CW + 16)'(mag[c] * time_step);
            prod_next[c] = src[c][CW-1] ? -$signed({1'b0, prod_w[c][CW+15:16]})
                                        : $signed({1'b0, prod_w[c][CW+15:16]});
            new_vel[c*CW +: CW] = sat_cw(64'(vr[c]) + 64'(prod_reg[c]));
            new_pos[c*CW +: CW] = sat_cw(64'(pa[c]) + 64'(prod_reg[c]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && ld_ok)
        begin
            pos_mem[ld_addr] <= ld_pos;
        end
        else if (cmd.pos_wr)
        begin
            pos_mem[i_idx] <= new_pos;
        end
        if (cmd.rd)
        begin
            pos_a_reg <= pos_mem[i_idx];
            pos_b_reg <= pos_mem[j_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && ld_ok)
        begin
            vel_mem[ld_addr] <= '0;
        end
        else if (cmd.vel_wr)
        begin
            vel_mem[i_idx] <= new_vel;
        end
        if (cmd.rd)
        begin
            vel_rd_reg <= vel_mem[i_idx];
        end
    end

    // Velocities read as zero until their entry has been written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_vld_reg    <= '0;
            vel_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_wr && ld_ok)
            begin
                vel_vld_reg[ld_addr] <= 1'b1;
            end
            else if (cmd.vel_wr)
            begin
                vel_vld_reg[i_idx] <= 1'b1;
            end
            if (cmd.rd)
            begin
                vel_rd_vld_reg <= vel_vld_reg[i_idx];
            end
        end
    end

    nbg_pair #(
        .COORD_WIDTH (CW)
    ) u_pair (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.pair_start),
        .pos_i (pos_a_reg),
        .pos_j (pos_b_reg),
        .done  (pair_done),
        .term  (term)
    );

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.clr_acc)
            begin
                acc_reg[c] <= '0;
            end
            else if (pair_done)
            begin
                acc_reg[c] <= acc_reg[c] + nbg_pkg::ACC_W'(term[c]);
            end
            if (cmd.mul_force || cmd.mul_vel)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.pos_wr)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_wr)
        begin
            m_data_reg <= {2'b00,
                           sat32(new_pos[2*CW +: CW]),
                           sat32(new_pos[CW +: CW]),
                           sat32(new_pos[0 +: CW]),
                           nbg_pkg::IDX_FIELD_W'(i_idx)};
            m_last_reg <= cmd.last;
        end
    end

    assign m_axis_tvalid  = m_valid_reg;
    assign m_axis_tdata   = m_data_reg;
    assign m_axis_tlast   = m_last_reg;
    assign stat.pair_done = pair_done;
    assign stat.out_free  = !m_valid_reg || m_axis_tready;

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_wr |-> (!m_valid_reg || m_axis_tready))
        else $error("result register overwritten before transfer");

    a_vel_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vel_wr |-> $past(cmd.mul_force))
        else $error("velocity written without a fresh force product");

endmodule

// ===== hw/rtl/nbg_ctrl.sv =====
module nbg_ctrl #(
    parameter int MAX_PARTICLES = 64,
    parameter int IDX_W         = 6,
    parameter int CNT_W         = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic                          kind,
    input  logic [nbg_pkg::COUNT_W-1:0]   particles_in_use,
    input  nbg_pkg::stat_t                stat,
    output nbg_pkg::cmd_t                 cmd,
    output logic [IDX_W-1:0]              i_idx,
    output logic [IDX_W-1:0]              j_idx
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FI,
        S_FJ,
        S_FSTART,
        S_FWAIT,
        S_VRD,
        S_VMUL,
        S_VWR,
        S_PRD,
        S_PMUL,
        S_PWR
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [CNT_W-1:0]   n_reg;

    logic               accept;
    logic [CNT_W-1:0]   n_next;
    logic               i_last;
    logic               j_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign n_next        = (particles_in_use > nbg_pkg::COUNT_W'(MAX_PARTICLES))
                         ? CNT_W'(MAX_PARTICLES) : particles_in_use[CNT_W-1:0];
    assign i_last        = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    assign j_last        = (CNT_W'(j_reg) + CNT_W'(1)) == n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind == nbg_pkg::KIND_STEP && n_next != '0)
                    begin
                        n_reg     <= n_next;
                        i_reg     <= '0;
                        state_reg <= S_FI;
                    end
                end
                S_FI:
                begin
                    j_reg     <= '0;
                    state_reg <= S_FJ;
                end
                S_FJ:
                begin
                    if (j_reg == i_reg)
                    begin
                        if (j_last)
                        begin
                            state_reg <= S_VRD;
                        end
                        else
                        begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_FSTART;
                    end
                end
                S_FSTART: state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    if (stat.pair_done)
                    begin
                        if (j_last)
                        begin
                            state_reg <= S_VRD;
                        end
                        else
                        begin
                            j_reg     <= j_reg + IDX_W'(1);
                            state_reg <= S_FJ;
                        end
                    end
                end
                S_VRD:  state_reg <= S_VMUL;
                S_VMUL: state_reg <= S_VWR;
                S_VWR:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_PRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_FI;
                    end
                end
                S_PRD:  state_reg <= S_PMUL;
                S_PMUL: state_reg <= S_PWR;
                S_PWR:
                begin
                    if (stat.out_free)
                    begin
                        if (i_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_PRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load_wr    = accept && kind == nbg_pkg::KIND_LOAD;
        cmd.clr_acc    = (state_reg == S_FI);
        cmd.rd         = (state_reg == S_FJ && j_reg != i_reg)
                      || state_reg == S_VRD || state_reg == S_PRD;
        cmd.pair_start = (state_reg == S_FSTART);
        cmd.mul_force  = (state_reg == S_VMUL);
        cmd.vel_wr     = (state_reg == S_VWR);
        cmd.mul_vel    = (state_reg == S_PMUL);
        cmd.pos_wr     = (state_reg == S_PWR) && stat.out_free;
        cmd.last       = i_last;
    end

    assign i_idx = i_reg;
    assign j_idx = j_reg;

    a_i_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> CNT_W'(i_reg) < n_reg)
        else $error("particle index beyond count");

    a_no_self_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FSTART |-> j_reg != i_reg)
        else $error("particle paired with itself");

endmodule

// ===== hw/rtl/nbody_gravity_step.sv =====
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: kind; tdata: load position
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: new position; tlast: last
// apb       in         psel/penable/pready           particles_in_use, time_step
//
// A load transfer is written in the cycle it is accepted. A step holds the input off
// until its last new position enters the output register; each pair goes through one
// iterative pair unit (normalising shifts, a 17-step square root and an 18-step divider),
// and a coincident pair skips the root and the divider.
// Reset clears control state and marks every velocity as zero; positions are
// undefined until loaded. Results wait in an output register, and a stalled
// output holds the position phase for each stalled cycle without losing a result.
module nbody_gravity_step #(
    parameter int MAX_PARTICLES = 64,
    parameter int COORD_WIDTH   = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [5:0] particle_index, [37:6] pos_x_in, [69:38] pos_y_in, [101:70] pos_z_in
    input  logic [103:0] s_axis_tdata,
    // [0] kind
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [5:0] out_index, [37:6] new_x, [69:38] new_y, [101:70] new_z
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    logic [nbg_pkg::COUNT_W-1:0] count_reg;
    logic [nbg_pkg::DT_W-1:0]    dt_reg;
    logic                        cfg_wr;

    nbg_pkg::cmd_t               cmd;
    nbg_pkg::stat_t              stat;
    logic [IDX_W-1:0]            i_idx;
    logic [IDX_W-1:0]            j_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 7'd64;
            dt_reg    <= 16'd655;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == nbg_pkg::REG_COUNT)
            begin
                count_reg <= pwdata[nbg_pkg::COUNT_W-1:0];
            end
            else
            begin
                dt_reg <= pwdata[nbg_pkg::DT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == nbg_pkg::REG_DT) ? {16'd0, dt_reg} : {25'd0, count_reg};

    nbg_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .kind             (s_axis_tuser[0]),
        .particles_in_use (count_reg),
        .stat             (stat),
        .cmd              (cmd),
        .i_idx            (i_idx),
        .j_idx            (j_idx)
    );

    nbg_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .COORD_WIDTH   (COORD_WIDTH),
        .IDX_W         (IDX_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .i_idx         (i_idx),
        .j_idx         (j_idx),
        .ld_index      (s_axis_tdata[5:0]),
        .ld_x          ($signed(s_axis_tdata[37:6])),
        .ld_y          ($signed(s_axis_tdata[69:38])),
        .ld_z          ($signed(s_axis_tdata[101:70])),
        .time_step     (dt_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/nbody_gravity_step_test.sv =====
module nbody_gravity_step_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [5:0]  index;
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] z;
        bit        last;
    } new_position_t;

    class gravity_scoreboard;
        longint        pos_x[64], pos_y[64], pos_z[64];
        longint        vel_x[64], vel_y[64], vel_z[64];
        int unsigned   count_reg;
        longint        dt_reg;
        new_position_t positions_due[$];
        int            errors;

        function void clear();
            foreach (pos_x[i])
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                vel_x[i] = 0; vel_y[i] = 0; vel_z[i] = 0;
            end
            count_reg = 64;
            dt_reg = 655;
            errors = 0;
        endfunction

        function void set_register(bit index, int unsigned value);
            if (index == nbg_pkg::REG_COUNT)
                count_reg = value & 7'h7f;
            else
                dt_reg = value & 16'hffff;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sh7fffffff)
                return 64'sh7fffffff;
            if (v < -64'sh80000000)
                return -64'sh80000000;
            return v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint scale_dt(longint v);
            longint unsigned mag;
            longint          r;
            mag = (v < 0) ? longint'(-v) : longint'(v);
            r = longint'((mag * longint'(dt_reg)) >> 16);
            return (v < 0) ? -r : r;
        endfunction

        // Adds d/|d|^3 for one pair into f, normalised so the largest
        // component lands in [2^15, 2^16) before the square root.
        function void add_pull(longint d[3], inout longint f[3]);
            longint unsigned mag[3], a[3];
            longint unsigned m, s, r, den, base, t;
            int bl, k, e;
            m = 0;
            s = 0;
            bl = 0;
            for (int c = 0; c < 3; c++)
            begin
                mag[c] = (d[c] < 0) ? longint'(-d[c]) : longint'(d[c]);
                if (mag[c] > m)
                    m = mag[c];
            end
            if (m == 0)
                return;
            while (bl < 64 && (m >> bl) != 0)
                bl++;
            k = bl - 16;
            for (int c = 0; c < 3; c++)
            begin
                a[c] = (k >= 0) ? (mag[c] >> k) : (mag[c] << (-k));
                s = s + a[c] * a[c];
            end
            r = int_sqrt(s);
            den = s * r;
            e = 1 - 2 * k;
            for (int c = 0; c < 3; c++)
            begin
                base = (a[c] << 47) / den;
                if (e >= 0)
                    t = (base > ((64'd1 << 52) >> e)) ? (64'd1 << 52) : (base << e);
                else
                    t = (-e >= 64) ? 0 : (base >> (-e));
                f[c] = (d[c] < 0) ? f[c] - longint'(t) : f[c] + longint'(t);
            end
        endfunction

        function void note_input(bit kind, bit [5:0] index, bit [31:0] x, bit [31:0] y,
                                 bit [31:0] z);
            longint        fx[64], fy[64], fz[64];
            longint        f[3], d[3];
            int            n;
            new_position_t res;
            if (kind == nbg_pkg::KIND_LOAD)
            begin
                pos_x[index] = longint'(signed'(x));
                pos_y[index] = longint'(signed'(y));
                pos_z[index] = longint'(signed'(z));
                vel_x[index] = 0; vel_y[index] = 0; vel_z[index] = 0;
                return;
            end
            n = (count_reg > 64) ? 64 : count_reg;
            for (int i = 0; i < n; i++)
            begin
                f[0] = 0; f[1] = 0; f[2] = 0;
                for (int j = 0; j < n; j++)
                begin
                    if (j != i)
                    begin
                        d[0] = pos_x[j] - pos_x[i];
                        d[1] = pos_y[j] - pos_y[i];
                        d[2] = pos_z[j] - pos_z[i];
                        add_pull(d, f);
                    end
                end
                fx[i] = sat32(f[0]); fy[i] = sat32(f[1]); fz[i] = sat32(f[2]);
            end
            for (int i = 0; i < n; i++)
            begin
                vel_x[i] = sat32(vel_x[i] + scale_dt(fx[i]));
                vel_y[i] = sat32(vel_y[i] + scale_dt(fy[i]));
                vel_z[i] = sat32(vel_z[i] + scale_dt(fz[i]));
            end
            for (int i = 0; i < n; i++)
            begin
                pos_x[i] = sat32(pos_x[i] + scale_dt(vel_x[i]));
                pos_y[i] = sat32(pos_y[i] + scale_dt(vel_y[i]));
                pos_z[i] = sat32(pos_z[i] + scale_dt(vel_z[i]));
                res.index = 6'(i);
                res.x = pos_x[i][31:0];
                res.y = pos_y[i][31:0];
                res.z = pos_z[i][31:0];
                res.last = (i + 1 == n);
                positions_due.push_back(res);
            end
        endfunction

        function void check_result(bit [103:0] data, bit last);
            new_position_t want;
            if (positions_due.size() == 0)
            begin
                $error("unexpected result transfer: tdata %h", data);
                errors++;
                return;
            end
            want = positions_due.pop_front();
            if (data[5:0] != want.index)
            begin
                $error("out_index: expected %0d, actual %0d", want.index, data[5:0]);
                errors++;
            end
            if (data[37:6] != want.x)
            begin
                $error("new_x: expected %h, actual %h", want.x, data[37:6]);
                errors++;
            end
            if (data[69:38] != want.y)
            begin
                $error("new_y: expected %h, actual %h", want.y, data[69:38]);
                errors++;
            end
            if (data[101:70] != want.z)
            begin
                $error("new_z: expected %h, actual %h", want.z, data[101:70]);
                errors++;
            end
            if (last != want.last)
            begin
                $error("last_particle: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    gravity_scoreboard gravity_sb;
    int  results_seen;
    int  hold_left;
    bit  hold_done;
    bit  quiet_mode;

    nbody_gravity_step DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: checks each transfer and stalls at random, with one long
    // hold-off after the first result, while a second step is already being
    // offered, so that the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            results_seen <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                gravity_sb.check_result(m_axis_tdata, m_axis_tlast);
                results_seen <= results_seen + 1;
            end
            if (!hold_done && results_seen == 1)
            begin
                hold_done <= 1'b1;
                hold_left <= 3000;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (quiet_mode)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 299) == 0)
            begin
                hold_left <= $urandom_range(20, 80);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    task automatic write_register(bit index, int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gravity_sb.set_register(index, value);
    endtask

    // Offers one item and returns once it has been accepted; tvalid stays
    // high when no gap follows, so back-to-back items are offered without a break.
    task automatic send_item(bit kind, bit [5:0] index, bit [31:0] x, bit [31:0] y,
                             bit [31:0] z);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b00, z, y, x, index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        gravity_sb.note_input(kind, index, x, y, z);
        if (quiet_mode)
            gap = 0;
        else if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(20, 60);
        else
            gap = $urandom_range(0, 2);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load(bit [5:0] index, bit [31:0] x, bit [31:0] y, bit [31:0] z);
        send_item(nbg_pkg::KIND_LOAD, index, x, y, z);
    endtask

    task automatic step();
        send_item(nbg_pkg::KIND_STEP, 6'($urandom), $urandom, $urandom, $urandom);
    endtask

    // Waits until every result is in, then gives the block time to finish
    // work that produces nothing, such as loads or an empty step.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (gravity_sb.positions_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic bit [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            2: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    initial
    begin
        #25_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        gravity_sb = new();
        gravity_sb.clear();
        quiet_mode = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = nbg_pkg::KIND_LOAD;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opposite corners of the coordinate range, with the largest dt.
        write_register(nbg_pkg::REG_COUNT, 2);
        write_register(nbg_pkg::REG_DT, 65535);
        load(0, 32'h7fffffff, 32'h80000000, 32'h0);
        load(1, 32'h80000000, 32'h7fffffff, 32'h1);
        step();
        step();
        settle();

        // Coincident particles feel nothing from each other.
        load(0, 32'h0005_0000, 32'hfffb_0000, 32'h0000_8000);
        load(1, 32'h0005_0000, 32'hfffb_0000, 32'h0000_8000);
        step();
        settle();

        write_register(nbg_pkg::REG_COUNT, 8);
        write_register(nbg_pkg::REG_DT, 1);
        for (int i = 0; i < 8; i++)
            load(i, rand_coord(), rand_coord(), rand_coord());
        step();
        settle();

        // A single particle only drifts; an empty count emits nothing.
        write_register(nbg_pkg::REG_COUNT, 1);
        step();
        settle();
        write_register(nbg_pkg::REG_COUNT, 0);
        step();
        settle();

        for (int round = 0; round < 12; round++)
        begin
            // Registers only change once the previous step has finished.
            settle();
            quiet_mode = (round % 4 == 3);
            write_register(nbg_pkg::REG_COUNT, $urandom_range(2, 8));
            case ($urandom_range(0, 3))
                0: write_register(nbg_pkg::REG_DT, 1);
                1: write_register(nbg_pkg::REG_DT, 65535);
                default: write_register(nbg_pkg::REG_DT, $urandom_range(1, 65535));
            endcase
            for (int item = 0; item < 6; item++)
            begin
                if ($urandom_range(0, 9) < 6)
                    load($urandom_range(0, 9), rand_coord(), rand_coord(), rand_coord());
                else
                    step();
            end
            if (round == 6)
                settle();
        end
        settle();
        quiet_mode = 1'b0;

        // Full set of particles; a count above the array size acts as 64.
        for (int i = 0; i < 64; i++)
            load(i, rand_coord(), rand_coord(), rand_coord());
        settle();
        write_register(nbg_pkg::REG_COUNT, 127);
        write_register(nbg_pkg::REG_DT, 655);
        step();
        settle();

        if (gravity_sb.errors == 0 && gravity_sb.positions_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
